[sv/potl_pkg.sv]
// Shared types and constants for the priority ordered task list.
// Depends on nothing; all files but potl_ram refer to it by scoped names.
package potl_pkg;

	// Default sizes of the block.
	localparam int SLOTS_DEF     = 32;
	localparam int PRIO_BITS_DEF = 8;

	// Beat field widths, fixed by the channel format.
	localparam int MODE_W     = 2;
	localparam int REQ_PRIO_W = 8;
	localparam int SLOT_W     = 5;
	localparam int ENTRY_W    = 5;
	localparam int OUT_PRIO_W = 8;
	localparam int STATUS_W   = 2;

	// A tick lists at most this many entries.
	localparam int RESULT_CAP = 32;
	localparam int EMIT_W     = $clog2(RESULT_CAP + 1);

	// Request modes.
	typedef enum logic [MODE_W-1:0] {
		MODE_CREATE   = 2'd0,
		MODE_KILL     = 2'd1,
		MODE_KILL_ALL = 2'd2,
		MODE_TICK     = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_NONE       = 2'd2,
		STAT_NOT_ACTIVE = 2'd3
	} status_t;

	// Operations broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		OP_HOLD     = 3'd0,
		OP_INSERT   = 3'd1,
		OP_KILL     = 3'd2,
		OP_KILL_ALL = 3'd3,
		OP_ROTATE   = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     keep_head;
	} cell_cmd_t;

endpackage

[sv/potl_if.sv]
// Valid/ready channel interfaces for the request and result beats.
// Depends on potl_pkg for the field widths.
interface potl_req_if;
	logic                              valid;
	logic                              ready;
	logic [potl_pkg::MODE_W-1:0]       mode;
	logic [potl_pkg::REQ_PRIO_W-1:0]   priority_req;
	logic [potl_pkg::SLOT_W-1:0]       slot;

	modport source (output valid, output mode, output priority_req, output slot, input ready);
	modport sink (input valid, input mode, input priority_req, input slot, output ready);
endinterface

interface potl_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [potl_pkg::ENTRY_W-1:0]      entry;
	logic [potl_pkg::OUT_PRIO_W-1:0]   entry_priority;
	logic [potl_pkg::STATUS_W-1:0]     status;
	logic                              last;

	modport source (output valid, output entry, output entry_priority, output status,
		output last, input ready);
	modport sink (input valid, input entry, input entry_priority, input status,
		input last, output ready);
endinterface

[sv/potl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module potl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while no read is requested.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/potl_cell.sv]
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
// Depends on potl_pkg for the cell command struct.
module potl_cell #(
	parameter int IW = 5,
	parameter int PW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  potl_pkg::cell_cmd_t cmd,
	input  logic [IW-1:0]       new_id,
	input  logic [PW-1:0]       new_prio,
	input  logic [IW-1:0]       kill_id,
	input  logic [IW-1:0]       head_id,
	input  logic [PW-1:0]       head_prio,
	input  logic                left_valid,
	input  logic [IW-1:0]       left_id,
	input  logic [PW-1:0]       left_prio,
	input  logic                left_mark,
	input  logic                left_gt,
	input  logic                right_valid,
	input  logic [IW-1:0]       right_id,
	input  logic [PW-1:0]       right_prio,
	input  logic                right_mark,
	output logic                valid,
	output logic [IW-1:0]       id,
	output logic [PW-1:0]       prio,
	output logic                mark,
	output logic                gt
);

	logic          valid_q;
	logic          mark_q;
	logic [IW-1:0] id_q;
	logic [PW-1:0] prio_q;
	logic          nxt_valid;
	logic          nxt_mark;
	logic [IW-1:0] nxt_id;
	logic [PW-1:0] nxt_prio;

	// This entry sorts after a new entry of the requested priority.
	assign gt = valid_q && (prio_q > new_prio);

	// Next contents of the cell.
	always_comb begin
		nxt_valid = valid_q;
		nxt_mark  = mark_q;
		nxt_id    = id_q;
		nxt_prio  = prio_q;
		case (cmd.op)
			potl_pkg::OP_INSERT: begin
				// Entries that sort after the new one move one cell to the right.
				if (left_gt) begin
					nxt_valid = 1'b1;
					nxt_mark  = left_mark;
					nxt_id    = left_id;
					nxt_prio  = left_prio;
				end else if ((gt || !valid_q) && left_valid) begin
					nxt_valid = 1'b1;
					nxt_mark  = 1'b0;
					nxt_id    = new_id;
					nxt_prio  = new_prio;
				end
			end
			potl_pkg::OP_KILL: begin
				if (valid_q && (id_q == kill_id)) begin
					nxt_mark = 1'b1;
				end
			end
			potl_pkg::OP_KILL_ALL: begin
				nxt_mark = mark_q || valid_q;
			end
			potl_pkg::OP_ROTATE: begin
				// Shift toward the head; the last occupied cell takes a kept head entry.
				if (right_valid) begin
					nxt_valid = 1'b1;
					nxt_mark  = right_mark;
					nxt_id    = right_id;
					nxt_prio  = right_prio;
				end else if (valid_q && cmd.keep_head) begin
					nxt_valid = 1'b1;
					nxt_mark  = 1'b0;
					nxt_id    = head_id;
					nxt_prio  = head_prio;
				end else begin
					nxt_valid = 1'b0;
					nxt_mark  = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Control bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q  <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
			mark_q  <= nxt_mark;
		end
	end

	// Entry payload.
	always_ff @(posedge clk) begin
		id_q   <= nxt_id;
		prio_q <= nxt_prio;
	end

	assign valid = valid_q;
	assign mark  = mark_q;
	assign id    = id_q;
	assign prio  = prio_q;

endmodule

[sv/priority_ordered_task_list_top.sv]
// Create, kill-all and refused requests give their result beat in the cycle after
// acceptance; a successful kill passes through the S_KILL state, where the priority RAM
// read returns, before it gives its beat. Create, kill-all and refused kills take one
// request per cycle while results are taken; a successful kill holds the input in S_KILL.
// A tick holds it for the sweep: one step per chained entry, marked ones included.
// Reset clears the chain, the slot bitmaps and the output register at once.
module priority_ordered_task_list_top #(
	parameter int SLOTS     = potl_pkg::SLOTS_DEF,
	parameter int PRIO_BITS = potl_pkg::PRIO_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	potl_req_if.sink  req,
	potl_rsp_if.source rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = potl_pkg::EMIT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_KILL,
		S_ROT
	} state_t;

	state_t                  state_q;
	logic [SLOTS-1:0]        on_bits_q;
	logic [SLOTS-1:0]        mark_bits_q;
	logic [CW-1:0]           on_cnt_q;
	logic [CW-1:0]           used_cnt_q;
	logic [CW-1:0]           rem_q;
	logic [EW-1:0]           emit_q;
	logic [potl_pkg::SLOT_W-1:0] kill_slot_q;
	logic                    rsp_valid_q;
	logic [potl_pkg::ENTRY_W-1:0]    entry_q;
	logic [potl_pkg::OUT_PRIO_W-1:0] prio_q;
	potl_pkg::status_t       status_q;
	logic                    last_q;

	logic                    out_free;
	logic                    accept;
	potl_pkg::mode_t         req_mode;
	logic [PRIO_BITS-1:0]    req_prio;
	logic [IW-1:0]           slot_idx;
	logic                    kill_ok;
	logic [SLOTS-1:0]        used_bits;
	logic [IW-1:0]           free_idx;
	logic                    full;
	logic                    emit_now;
	logic                    step;
	logic                    tick_last;
	logic                    rsp_load;
	logic [PRIO_BITS-1:0]    ram_rdata;
	potl_pkg::cell_cmd_t     cmd;

	logic                    cell_valid [SLOTS];
	logic [IW-1:0]           cell_id    [SLOTS];
	logic [PRIO_BITS-1:0]    cell_prio  [SLOTS];
	logic                    cell_mark  [SLOTS];
	logic                    cell_gt    [SLOTS];

	// Request decode.
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign req_mode  = potl_pkg::mode_t'(req.mode);
	assign req_prio  = PRIO_BITS'({8'd0, req.priority_req});
	assign slot_idx  = IW'(req.slot);
	assign kill_ok   = (32'(req.slot) < SLOTS) && on_bits_q[slot_idx];

	// Lowest free slot.
	assign used_bits = on_bits_q | mark_bits_q;
	assign full      = &used_bits;
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_bits[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	// Tick sweep: one entry leaves the head cell per step.
	assign emit_now  = cell_valid[0] && !cell_mark[0] && (emit_q < EW'(potl_pkg::RESULT_CAP));
	assign step      = (state_q == S_ROT) && (!emit_now || out_free);
	assign tick_last = (emit_q == EW'(potl_pkg::RESULT_CAP - 1))
		|| ((32'(emit_q) + 32'd1) == 32'(on_cnt_q));

	// A new result beat enters the output register in this cycle.
	always_comb begin
		rsp_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_mode)
						potl_pkg::MODE_KILL: rsp_load = !kill_ok;
						potl_pkg::MODE_TICK: rsp_load = (on_cnt_q == '0);
						default: rsp_load = 1'b1;
					endcase
				end
			end
			S_KILL: rsp_load = out_free;
			S_ROT: rsp_load = step && emit_now;
			default: rsp_load = 1'b0;
		endcase
	end

	// Command broadcast to the chain.
	always_comb begin
		cmd.op        = potl_pkg::OP_HOLD;
		cmd.keep_head = !cell_mark[0];
		if (accept) begin
			case (req_mode)
				potl_pkg::MODE_CREATE: begin
					if (!full) begin
						cmd.op = potl_pkg::OP_INSERT;
					end
				end
				potl_pkg::MODE_KILL: begin
					if (kill_ok) begin
						cmd.op = potl_pkg::OP_KILL;
					end
				end
				potl_pkg::MODE_KILL_ALL: begin
					cmd.op = potl_pkg::OP_KILL_ALL;
				end
				default: begin
				end
			endcase
		end else if (step) begin
			cmd.op = potl_pkg::OP_ROTATE;
		end
	end

	// Priority per slot, read back for a kill result.
	potl_ram #(
		.WIDTH(PRIO_BITS),
		.DEPTH(SLOTS)
	) u_prio_ram (
		.clk  (clk),
		.we   (accept && (req_mode == potl_pkg::MODE_CREATE) && !full),
		.waddr(free_idx),
		.wdata(req_prio),
		.re   (accept),
		.raddr(slot_idx),
		.rdata(ram_rdata)
	);

	// Chain of cells, head at cell zero.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic                 l_valid;
		logic [IW-1:0]        l_id;
		logic [PRIO_BITS-1:0] l_prio;
		logic                 l_mark;
		logic                 l_gt;
		logic                 r_valid;
		logic [IW-1:0]        r_id;
		logic [PRIO_BITS-1:0] r_prio;
		logic                 r_mark;

		if (i == 0) begin : g_first
			assign l_valid = 1'b1;
			assign l_id    = '0;
			assign l_prio  = '0;
			assign l_mark  = 1'b0;
			assign l_gt    = 1'b0;
		end else begin : g_inner_l
			assign l_valid = cell_valid[i-1];
			assign l_id    = cell_id[i-1];
			assign l_prio  = cell_prio[i-1];
			assign l_mark  = cell_mark[i-1];
			assign l_gt    = cell_gt[i-1];
		end

		if (i == SLOTS - 1) begin : g_lastc
			assign r_valid = 1'b0;
			assign r_id    = '0;
			assign r_prio  = '0;
			assign r_mark  = 1'b0;
		end else begin : g_inner_r
			assign r_valid = cell_valid[i+1];
			assign r_id    = cell_id[i+1];
			assign r_prio  = cell_prio[i+1];
			assign r_mark  = cell_mark[i+1];
		end

		potl_cell #(
			.IW(IW),
			.PW(PRIO_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_id     (free_idx),
			.new_prio   (req_prio),
			.kill_id    (slot_idx),
			.head_id    (cell_id[0]),
			.head_prio  (cell_prio[0]),
			.left_valid (l_valid),
			.left_id    (l_id),
			.left_prio  (l_prio),
			.left_mark  (l_mark),
			.left_gt    (l_gt),
			.right_valid(r_valid),
			.right_id   (r_id),
			.right_prio (r_prio),
			.right_mark (r_mark),
			.valid      (cell_valid[i]),
			.id         (cell_id[i]),
			.prio       (cell_prio[i]),
			.mark       (cell_mark[i]),
			.gt         (cell_gt[i])
		);
	end

	// Sequencer, slot bookkeeping and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			on_bits_q   <= '0;
			mark_bits_q <= '0;
			on_cnt_q    <= '0;
			used_cnt_q  <= '0;
			rem_q       <= '0;
			emit_q      <= '0;
			kill_slot_q <= '0;
			rsp_valid_q <= 1'b0;
			entry_q     <= '0;
			prio_q      <= '0;
			status_q    <= potl_pkg::STAT_OK;
			last_q      <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_mode)
							potl_pkg::MODE_CREATE: begin
								last_q      <= 1'b1;
								if (full) begin
									entry_q  <= '0;
									prio_q   <= '0;
									status_q <= potl_pkg::STAT_FULL;
								end else begin
									entry_q             <= potl_pkg::ENTRY_W'(free_idx);
									prio_q              <= potl_pkg::OUT_PRIO_W'(req_prio);
									status_q            <= potl_pkg::STAT_OK;
									on_bits_q[free_idx] <= 1'b1;
									on_cnt_q            <= on_cnt_q + CW'(1);
									used_cnt_q          <= used_cnt_q + CW'(1);
								end
							end
							potl_pkg::MODE_KILL: begin
								if (kill_ok) begin
									kill_slot_q           <= req.slot;
									on_bits_q[slot_idx]   <= 1'b0;
									mark_bits_q[slot_idx] <= 1'b1;
									on_cnt_q              <= on_cnt_q - CW'(1);
									state_q               <= S_KILL;
								end else begin
									entry_q     <= req.slot;
									prio_q      <= '0;
									status_q    <= potl_pkg::STAT_NOT_ACTIVE;
									last_q      <= 1'b1;
								end
							end
							potl_pkg::MODE_KILL_ALL: begin
								entry_q     <= '0;
								prio_q      <= '0;
								status_q    <= (on_cnt_q != '0) ? potl_pkg::STAT_OK
									: potl_pkg::STAT_NONE;
								last_q      <= 1'b1;
								mark_bits_q <= mark_bits_q | on_bits_q;
								on_bits_q   <= '0;
								on_cnt_q    <= '0;
							end
							default: begin
								// Tick: every marked entry is freed by the sweep.
								mark_bits_q <= '0;
								if (on_cnt_q == '0) begin
									entry_q     <= '0;
									prio_q      <= '0;
									status_q    <= potl_pkg::STAT_NONE;
									last_q      <= 1'b1;
								end
								if (used_cnt_q != '0) begin
									rem_q   <= used_cnt_q;
									emit_q  <= '0;
									state_q <= S_ROT;
								end
							end
						endcase
					end
				end
				S_KILL: begin
					if (out_free) begin
						entry_q     <= kill_slot_q;
						prio_q      <= potl_pkg::OUT_PRIO_W'(ram_rdata);
						status_q    <= potl_pkg::STAT_OK;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_ROT: begin
					if (step) begin
						if (emit_now) begin
							entry_q     <= potl_pkg::ENTRY_W'(cell_id[0]);
							prio_q      <= potl_pkg::OUT_PRIO_W'(cell_prio[0]);
							status_q    <= potl_pkg::STAT_OK;
							last_q      <= tick_last;
							emit_q      <= emit_q + EW'(1);
						end
						if (cell_mark[0]) begin
							used_cnt_q <= used_cnt_q - CW'(1);
						end
						rem_q <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.entry          = entry_q;
	assign rsp.entry_priority = prio_q;
	assign rsp.status         = status_q;
	assign rsp.last           = last_q;

endmodule

[sv/potl_checker.sv]
// Port-level assertions on the result channel, bound to the top level.
// Depends on potl_pkg for the status codes and on priority_ordered_task_list_top.
module potl_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [potl_pkg::ENTRY_W-1:0]        rsp_entry,
	input logic [potl_pkg::OUT_PRIO_W-1:0]     rsp_entry_priority,
	input logic [potl_pkg::STATUS_W-1:0]       rsp_status,
	input logic                                rsp_last
);

	// A result beat stays offered until it is taken.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped before it was taken");

	// Every refused or empty answer is a single beat.
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != potl_pkg::STAT_OK) |-> rsp_last)
		else $error("error status beat without last");

	// Full and none answers carry no entry.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_status == potl_pkg::STAT_FULL)
			|| (rsp_status == potl_pkg::STAT_NONE))
		|-> (rsp_entry == '0) && (rsp_entry_priority == '0))
		else $error("full or none beat carries an entry");

	// A kill of an inactive slot reports no priority.
	a_not_active_prio: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == potl_pkg::STAT_NOT_ACTIVE) |-> (rsp_entry_priority == '0))
		else $error("inactive slot beat carries a priority");

endmodule

bind priority_ordered_task_list_top potl_checker u_potl_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_entry         (rsp.entry),
	.rsp_entry_priority(rsp.entry_priority),
	.rsp_status        (rsp.status),
	.rsp_last          (rsp.last)
);
